// ===== hw/rtl/rhd_pkg.sv =====
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared constants and types for the RGBA half downscaler.
// ----------------------------------------------------------------------------
package rhd_pkg;

  // Largest frame dimension that the counters must cover
  localparam int unsigned MaxDim  = 4096;
  // Counter width: holds 0 .. MaxDim-1
  localparam int unsigned CntW    = $clog2(MaxDim);
  // Dimension width: holds MaxDim itself
  localparam int unsigned DimW    = CntW + 1;
  // Configuration register width
  localparam int unsigned RegW    = 13;
  localparam int unsigned PixW    = 32;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef logic [DimW-1:0] dim_t;
  typedef logic [CntW-1:0] cnt_t;

  // One step of the wanted-index accumulator
  typedef struct packed {
    logic [1:0] step;
    cnt_t       rem;
  } adv_t;

endpackage

// ===== hw/rtl/rgba_half_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// rgba_half_downscaler_top
// Nearest-neighbour halving of a raster-order RGBA pixel stream.
// Output: a kept pixel is registered and appears on the output in the cycle after its input beat.
// Throughput: one input beat per cycle; the single output register sets it,
//   and input stalls only while that register is full and the output stalls.
// Reset: asynchronous, active low; both dimensions reset to 1 and all frame
//   counters to zero. Any register write restarts the frame.
// ----------------------------------------------------------------------------
module rgba_half_downscaler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rhd_pkg::AddrW-1:0]   paddr,
  input  logic [rhd_pkg::DataW-1:0]   pwdata,
  output logic [rhd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // source pixels
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rhd_pkg::PixW-1:0]    pixel_in_i,
  // kept pixels
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rhd_pkg::PixW-1:0]    pixel_out_o,
  output logic                        row_end_o,
  output logic                        frame_end_o
);

  import rhd_pkg::*;

  // Registers and frame counters
  logic [RegW-1:0] width_q, width_d, height_q, height_d;
  cnt_t            in_col_q, in_col_d, in_row_q, in_row_d;
  dim_t            want_col_q, want_col_d, want_row_q, want_row_d;
  cnt_t            col_rem_q, col_rem_d, row_rem_q, row_rem_d;
  cnt_t            out_col_q, out_col_d, out_row_q, out_row_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] pixel_q;
  logic            row_end_q, frame_end_q;

  logic            cfg_wr, in_acc;
  dim_t            w_eff, h_eff;
  cnt_t            half_w, half_h;
  logic            col_hit, row_hit, last_col, last_row, hit_row_end, hit_frame_end;
  adv_t            col_adv, row_adv;

  // Clamp a register value to 1 .. MaxDim
  function automatic dim_t eff_size(logic [RegW-1:0] raw);
    dim_t v;
    v = DimW'(raw);
    if (raw == '0) begin
      v = DimW'(1);
    end else if (32'(raw) > MaxDim) begin
      v = DimW'(MaxDim);
    end
    return v;
  endfunction

  // ceil(total/2)
  function automatic cnt_t half_of(dim_t total);
    logic [DimW:0] s;
    s = {1'b0, total} + (DimW+1)'(1);
    return s[CntW:1];
  endfunction

  // Step by total/half with remainder carry
  function automatic adv_t advance(dim_t total, cnt_t half, cnt_t rem);
    adv_t          a;
    cnt_t          r;
    logic [CntW:0] sum;
    r   = total[0] ? cnt_t'(half - cnt_t'(1)) : '0;
    sum = {1'b0, rem} + {1'b0, r};
    a.step = total[0] ? 2'd1 : 2'd2;
    if (sum >= {1'b0, half}) begin
      sum    = sum - {1'b0, half};
      a.step = a.step + 2'd1;
    end
    a.rem = sum[CntW-1:0];
    return a;
  endfunction

  // Handshakes
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Register read-back
  always_comb begin
    if (paddr[2] == RegHeight) begin
      prdata = DataW'(height_q);
    end else begin
      prdata = DataW'(width_q);
    end
  end

  // Selection decode from the current position
  assign w_eff    = eff_size(width_q);
  assign h_eff    = eff_size(height_q);
  assign half_w   = half_of(w_eff);
  assign half_h   = half_of(h_eff);
  assign col_hit  = ({1'b0, in_col_q} == want_col_q);
  assign row_hit  = ({1'b0, in_row_q} == want_row_q);
  assign last_col = ({1'b0, in_col_q} >= dim_t'(w_eff - dim_t'(1)));
  assign last_row = ({1'b0, in_row_q} >= dim_t'(h_eff - dim_t'(1)));
  assign col_adv  = advance(w_eff, half_w, col_rem_q);
  assign row_adv  = advance(h_eff, half_h, row_rem_q);
  assign hit_row_end   = (out_col_q == cnt_t'(half_w - cnt_t'(1)));
  assign hit_frame_end = hit_row_end && (out_row_q == cnt_t'(half_h - cnt_t'(1)));

  // Counter next state
  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    want_col_d = want_col_q;
    want_row_d = want_row_q;
    col_rem_d  = col_rem_q;
    row_rem_d  = row_rem_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    if (cfg_wr) begin
      if (paddr[2] == RegHeight) begin
        height_d = pwdata[RegW-1:0];
      end else begin
        width_d = pwdata[RegW-1:0];
      end
      in_col_d   = '0;
      in_row_d   = '0;
      want_col_d = '0;
      want_row_d = '0;
      col_rem_d  = '0;
      row_rem_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
    end else if (in_acc) begin
      if (col_hit) begin
        want_col_d = want_col_q + DimW'(col_adv.step);
        col_rem_d  = col_adv.rem;
        out_col_d  = out_col_q + cnt_t'(1);
      end
      if (!last_col) begin
        in_col_d = in_col_q + cnt_t'(1);
      end else begin
        // end of source row
        in_col_d   = '0;
        want_col_d = '0;
        col_rem_d  = '0;
        out_col_d  = '0;
        if (last_row) begin
          in_row_d   = '0;
          want_row_d = '0;
          row_rem_d  = '0;
          out_row_d  = '0;
        end else begin
          if (row_hit) begin
            want_row_d = want_row_q + DimW'(row_adv.step);
            row_rem_d  = row_adv.rem;
            out_row_d  = out_row_q + cnt_t'(1);
          end
          in_row_d = in_row_q + cnt_t'(1);
        end
      end
    end
  end

  // Output register fill and drain
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = col_hit && row_hit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RegW'(1);
      height_q    <= RegW'(1);
      in_col_q    <= '0;
      in_row_q    <= '0;
      want_col_q  <= '0;
      want_row_q  <= '0;
      col_rem_q   <= '0;
      row_rem_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      want_col_q  <= want_col_d;
      want_row_q  <= want_row_d;
      col_rem_q   <= col_rem_d;
      row_rem_q   <= row_rem_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the output beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pixel_q     <= pixel_in_i;
      row_end_q   <= hit_row_end;
      frame_end_q <= hit_frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

  // Checks
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_end_o || row_end_o))
    else $error("frame end without row end");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} <= dim_t'(w_eff - dim_t'(1)))
    else $error("source column beyond row");

  a_out_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_col_q <= half_w)
    else $error("kept column count beyond output width");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule

// ===== tb/sv/tb_rgba_half_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// tb_rgba_half_downscaler_top
// Self-checking bench for the RGBA half downscaler. Pixel frames of many
// sizes are streamed in, with random idling and stalls on both sides. An
// in-bench copy of the counter-based selection predicts each kept pixel and
// its row and frame marks, and the scoreboard checks every output beat.
// ----------------------------------------------------------------------------
module tb_rgba_half_downscaler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhd_pkg::*;

  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandBudget   = 400;
  localparam int unsigned HoldPixels   = 20;
  localparam int unsigned ClampPixels  = 40;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            row_end;
    logic            frame_end;
  } kept_t;

  // DUT signals, all inputs known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [DataW-1:0]  pwdata      = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [PixW-1:0]   pixel_in_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PixW-1:0]   pixel_out_o;
  logic              row_end_o;
  logic              frame_end_o;

  rgba_half_downscaler_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  // Source pixels waiting to be driven, kept pixels waiting to come out
  logic [PixW-1:0] pix_feed[$];
  kept_t           kept_q[$];
  kept_t           due_pix;
  kept_t           next_pix;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned pushed        = 0;
  int unsigned accepted      = 0;
  int unsigned checked       = 0;
  int unsigned frames_seen   = 0;
  int unsigned reg_writes    = 0;
  int unsigned errors        = 0;
  int unsigned quiet_cycles  = 0;
  bit          in_beat;
  bit          out_beat;

  // Selection model state: raw registers and frame counters
  logic [RegW-1:0] reg_width  = RegW'(1);
  logic [RegW-1:0] reg_height = RegW'(1);
  cnt_t src_col   = '0;
  cnt_t src_row   = '0;
  dim_t want_col  = '0;
  cnt_t col_rem   = '0;
  dim_t want_row  = '0;
  cnt_t row_rem   = '0;
  cnt_t kept_cols = '0;
  cnt_t kept_rows = '0;

  // ---------------------------------------------------------------------------
  // Selection model
  // ---------------------------------------------------------------------------

  // Zero reads as one, anything past the largest frame is clamped to it
  function automatic int unsigned eff_dim(input logic [RegW-1:0] r);
    if (r == '0) return 1;
    if (r > MaxDim) return MaxDim;
    return r;
  endfunction

  function automatic void clear_frame();
    src_col   = '0;
    src_row   = '0;
    want_col  = '0;
    col_rem   = '0;
    want_row  = '0;
    row_rem   = '0;
    kept_cols = '0;
    kept_rows = '0;
  endfunction

  // Advance the next wanted source index by total / ceil(total/2)
  function automatic void step_wanted(input int unsigned total, inout dim_t wanted,
                                      inout cnt_t rem);
    int unsigned half;
    int unsigned q;
    int unsigned sum;
    half = (total + 1) / 2;
    q    = (total >= 2 * half) ? 2 : 1;
    sum  = rem + (total - q * half);
    if (sum >= half) begin
      sum = sum - half;
      q   = q + 1;
    end
    rem    = cnt_t'(sum);
    wanted = wanted + dim_t'(q);
  endfunction

  // One source pixel in; always fills res, and returns 1 when the pixel is kept
  function automatic bit halve_pixel(input logic [PixW-1:0] pix, output kept_t res);
    int unsigned w;
    int unsigned h;
    int unsigned out_w;
    int unsigned out_h;
    bit col_hit;
    bit row_hit;
    bit last_col;
    bit last_row;
    bit keep;
    w        = eff_dim(reg_width);
    h        = eff_dim(reg_height);
    out_w    = (w + 1) / 2;
    out_h    = (h + 1) / 2;
    col_hit  = (src_col == want_col);
    row_hit  = (src_row == want_row);
    last_col = (src_col >= w - 1);
    last_row = (src_row >= h - 1);
    keep     = col_hit && row_hit;
    res.pixel     = pix;
    res.row_end   = (kept_cols == out_w - 1);
    res.frame_end = res.row_end && (kept_rows == out_h - 1);
    if (col_hit) begin
      step_wanted(w, want_col, col_rem);
      kept_cols = kept_cols + 1'b1;
    end
    if (!last_col) begin
      src_col = src_col + 1'b1;
    end else begin
      src_col   = '0;
      want_col  = '0;
      col_rem   = '0;
      kept_cols = '0;
      if (last_row) begin
        clear_frame();
      end else begin
        if (row_hit) begin
          step_wanted(h, want_row, row_rem);
          kept_rows = kept_rows + 1'b1;
        end
        src_row = src_row + 1'b1;
      end
    end
    return keep;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Source driver: holds a stalled beat, otherwise offers the next pixel
  // unless it decides to idle this cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pix_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        pixel_in_i <= pix_feed.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink stall: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard; output is checked before the input beat of the
  // same edge is predicted, as a kept pixel is registered on its way out
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_beat = out_valid_o && !out_stall_i;
      in_beat  = in_valid_i && !in_stall_o;
      if (out_beat) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected beat: pixel %h row_end %b frame_end %b",
                   $time, pixel_out_o, row_end_o, frame_end_o);
          errors++;
        end else begin
          due_pix = kept_q.pop_front();
          if (pixel_out_o !== due_pix.pixel || row_end_o !== due_pix.row_end ||
              frame_end_o !== due_pix.frame_end) begin
            $display("%0t: expected pixel %h row_end %b frame_end %b, got %h %b %b",
                     $time, due_pix.pixel, due_pix.row_end, due_pix.frame_end,
                     pixel_out_o, row_end_o, frame_end_o);
            errors++;
          end
          if (due_pix.frame_end) frames_seen++;
          checked++;
        end
      end
      if (in_beat) begin
        if (halve_pixel(pixel_in_i, next_pix)) kept_q.push_back(next_pix);
        accepted++;
      end
      // watchdog on cycles with no beat and no register access
      quiet_cycles = (in_beat || out_beat || psel) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no beat for %0d cycles, %0d pixels still due",
                 $time, quiet_cycles, kept_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [PixW-1:0] pix);
    pix_feed.push_back(pix);
    pushed++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) push_pixel($urandom());
  endtask

  // Wait until every pixel is taken and every kept pixel has come out
  task automatic wait_drained();
    while (accepted != pushed || kept_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write, then read back in a second transfer; upper data bits random
  task automatic set_reg(input logic idx, input logic [RegW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= ($urandom() << RegW) | DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegWidth) reg_width = val;
    else reg_height = val;
    clear_frame();
    reg_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(val)) begin
      $display("%0t: register %0d read back: expected %h, got %h",
               $time, idx, DataW'(val), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly small sizes, some zeros, a few past the clamp
  function automatic logic [RegW-1:0] pick_dim();
    case ($urandom_range(19))
      0:       return '0;
      1:       return RegW'($urandom_range(8191, MaxDim + 1));
      2, 3:    return RegW'($urandom_range(64, 17));
      default: return RegW'($urandom_range(16, 1));
    endcase
  endfunction

  // Random frames under one idling setting; whole frames mostly, with broken
  // tails cut short by a register write and the odd mid-frame drain
  task automatic run_regime(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned start;
    int unsigned frame_px;
    int unsigned n;
    bit          held;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start = pushed;
    held  = 1'b0;
    while (pushed - start < RandBudget) begin
      case ($urandom_range(2))
        0: begin
          set_reg(RegWidth, pick_dim());
          set_reg(RegHeight, pick_dim());
        end
        1:       set_reg(RegWidth, pick_dim());
        default: set_reg(RegHeight, pick_dim());
      endcase
      frame_px = eff_dim(reg_width) * eff_dim(reg_height);
      if (frame_px > 2000) begin
        n = $urandom_range(300, 1);
      end else begin
        n = frame_px * $urandom_range(3, 1);
        if ($urandom_range(3) == 0 && frame_px > 1) n = n + $urandom_range(frame_px - 1, 1);
      end
      // stay within the pixel budget of this regime
      if (n > RandBudget - (pushed - start)) n = RandBudget - (pushed - start);
      // sender pauses part way until every kept pixel is out
      if ($urandom_range(4) == 0) begin
        push_random(n / 2);
        wait_drained();
        n = n - n / 2;
      end
      push_random(n);
      // long sink hold-off while the source keeps offering
      if (!held) begin
        hold_asked++;
        held = 1'b1;
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    src_idle_pct  = 23;
    sink_idle_pct = 55;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: single pixel frames, every pixel kept and marked
    push_pixel('0);
    push_pixel('1);
    push_pixel(32'hA5C3_3C5A);
    wait_drained();

    // zero sizes act as one
    set_reg(RegWidth, '0);
    set_reg(RegHeight, '0);
    push_random(2);
    wait_drained();

    // every pixel kept and the sink held off: output fills, input stalls
    push_random(HoldPixels);
    hold_asked++;
    wait_drained();

    // odd frame
    set_reg(RegWidth, RegW'(3));
    set_reg(RegHeight, RegW'(3));
    push_random(9);
    wait_drained();

    // a write part way through a frame restarts it
    set_reg(RegWidth, RegW'(4));
    set_reg(RegHeight, RegW'(2));
    push_random(3);
    wait_drained();
    set_reg(RegWidth, RegW'(2));
    push_random(4);
    wait_drained();

    run_regime(23, 55);
    run_regime(55, 23);
    run_regime(0, 0);

    // clamped sizes; the selection pattern differs from the first rows on
    set_reg(RegWidth, RegW'(8191));
    set_reg(RegHeight, '0);
    push_random(ClampPixels);
    wait_drained();
    set_reg(RegWidth, RegW'(1));
    set_reg(RegHeight, RegW'(MaxDim + 1));
    push_random(ClampPixels);
    wait_drained();

    if (kept_q.size() != 0) errors++;
    $display("Covered %0d source pixels, %0d kept pixels, %0d output frames,",
             accepted, checked, frames_seen);
    $display("%0d register writes; zero, odd and clamped sizes; stalls both sides.",
             reg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
